@@ sv/lpcd_pkg.sv @@
package lpcd_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int OFFSET_BITS_DEF = 48;

  localparam int PAGE_W     = 48;
  localparam int SLOT_W     = 6;
  localparam int MODE_W     = 2;
  localparam int OUT_DATA_W = 64;
  // hit, is_root, slot, evicted, evicted_page, writeback, not_present
  localparam int OUT_USED_W = 1 + 1 + SLOT_W + 1 + PAGE_W + 1 + 1;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // mode 0 and the unused code 3 are both plain reads
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_TOUCH = 2'd1,
    OP_DROP  = 2'd2
  } cell_op_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    cell_op_t op;
    logic     age_all;  // every other valid entry ages (insert / replace)
    logic     load;     // selected cell takes a new tag
    logic     dirty;    // write access
  } cell_cmd_t;

endpackage

@@ sv/lru_page_cache_directory.sv @@
// A request passes the compare state, then the update state, which writes its reply
// into the output register. A new request can be accepted in the update state of the
// previous one; the update state holds until the output register is free.
// Every cell compares its tag in parallel; the row gathers hit, victim and free slot.
// Reset (synchronous, rst_n low) clears valid, dirty, ranks, occupancy and root_page;
// tags are not cleared and no clearing pass runs.
module lru_page_cache_directory #(
  parameter int ENTRIES     = lpcd_pkg::ENTRIES_DEF,
  parameter int OFFSET_BITS = lpcd_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lpcd_pkg::PAGE_W-1:0]       in_tdata,   // [47:0] page_offset
  input  logic [lpcd_pkg::MODE_W-1:0]       in_tuser,   // [1:0] mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] hit, [1] is_root, [7:2] slot, [8] evicted, [56:9] evicted_page,
  // [57] writeback, [58] not_present, [63:59] zero
  output logic [lpcd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [lpcd_pkg::PAGE_W-1:0]       cfg_wr_data // root_page
);
  import lpcd_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int TAG_W  = (OFFSET_BITS < PAGE_W) ? OFFSET_BITS : PAGE_W;
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PAGE_W-1:0]   root_r;
  logic [MODE_W-1:0]   req_mode_r;
  logic [TAG_W-1:0]    req_page_r;
  logic [OCC_W-1:0]    occ_r;

  // row results
  logic                hit_any;
  logic [IDX_W-1:0]    hit_idx;
  logic [RANK_W-1:0]   hit_rank;
  logic [IDX_W-1:0]    victim_idx;
  logic [TAG_W-1:0]    victim_tag;
  logic                victim_dirty;
  logic [IDX_W-1:0]    free_idx;
  logic [ENTRIES-1:0]  valid_vec;

  // decision, computed in the compare cycle
  logic                is_root;
  logic                full;
  cell_cmd_t           d_cmd, dec_cmd_r;
  logic [IDX_W-1:0]    d_slot, dec_slot_r;
  logic [RANK_W-1:0]   dec_rank_r;
  logic                d_hit, dec_hit_r;
  logic                d_np, dec_np_r;
  logic                d_ev, dec_ev_r;
  logic                d_wb, dec_wb_r;
  logic [PAGE_W-1:0]   d_evp, dec_evp_r;
  logic                d_inc, dec_inc_r;
  logic                d_dec, dec_dec_r;
  logic                dec_root_r;

  logic                upd_go;
  logic                in_acc;
  cell_cmd_t           row_cmd;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_acc    = in_tvalid && in_tready;
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || upd_go;
  assign is_root   = (req_page_r == root_r[TAG_W-1:0]);
  assign full      = (occ_r >= OCC_FULL);

  lpcd_row #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .RANK_W  (RANK_W),
    .TAG_W   (TAG_W)
  ) u_row (
    .clk            (clk),
    .rst_n          (rst_n),
    .key_i          (req_page_r),
    .cmd_i          (row_cmd),
    .cmd_slot_i     (dec_slot_r),
    .cmd_rank_i     (dec_rank_r),
    .cmd_tag_i      (req_page_r),
    .hit_any_o      (hit_any),
    .hit_idx_o      (hit_idx),
    .hit_rank_o     (hit_rank),
    .victim_idx_o   (victim_idx),
    .victim_tag_o   (victim_tag),
    .victim_dirty_o (victim_dirty),
    .free_idx_o     (free_idx),
    .valid_vec_o    (valid_vec)
  );

  always_comb begin
    row_cmd    = dec_cmd_r;
    row_cmd.op = upd_go ? dec_cmd_r.op : OP_NONE;
  end

  always_comb begin
    d_cmd   = '{op: OP_NONE, age_all: 1'b0, load: 1'b0, dirty: 1'b0};
    d_slot  = '0;
    d_hit   = 1'b0;
    d_np    = 1'b0;
    d_ev    = 1'b0;
    d_wb    = 1'b0;
    d_evp   = '0;
    d_inc   = 1'b0;
    d_dec   = 1'b0;
    if (is_root) begin
      if (req_mode_r == MODE_FREE) d_np = 1'b1;
      else d_hit = 1'b1;
    end else if (req_mode_r == MODE_FREE) begin
      if (hit_any) begin
        d_hit    = 1'b1;
        d_slot   = hit_idx;
        d_cmd.op = OP_DROP;
        d_dec    = 1'b1;
      end else begin
        d_np = 1'b1;
      end
    end else begin
      d_cmd.op    = OP_TOUCH;
      d_cmd.dirty = (req_mode_r == MODE_WRITE);
      if (hit_any) begin
        d_hit  = 1'b1;
        d_slot = hit_idx;
      end else begin
        d_cmd.load    = 1'b1;
        d_cmd.age_all = 1'b1;
        if (full) begin
          d_slot = victim_idx;
          d_ev   = 1'b1;
          d_evp  = PAGE_W'(victim_tag);
          d_wb   = victim_dirty;
        end else begin
          d_slot = free_idx;
          d_inc  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (upd_go) state_nxt = in_acc ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      dec_cmd_r   <= '{op: OP_NONE, age_all: 1'b0, load: 1'b0, dirty: 1'b0};
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) root_r <= cfg_wr_data;
      if (state_r == S_CMP) dec_cmd_r <= d_cmd;
      if (upd_go) begin
        out_valid_r <= 1'b1;
        if (dec_inc_r) occ_r <= occ_r + 1'b1;
        else if (dec_dec_r) occ_r <= occ_r - 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode_r <= in_tuser;
      req_page_r <= in_tdata[TAG_W-1:0];
    end
    if (state_r == S_CMP) begin
      dec_slot_r <= d_slot;
      dec_rank_r <= hit_rank;
      dec_hit_r  <= d_hit;
      dec_root_r <= is_root;
      dec_np_r   <= d_np;
      dec_ev_r   <= d_ev;
      dec_wb_r   <= d_wb;
      dec_evp_r  <= d_evp;
      dec_inc_r  <= d_inc;
      dec_dec_r  <= d_dec;
    end
    if (upd_go) begin
      out_data_r <= {OUT_PAD_W'(0), dec_np_r, dec_wb_r, dec_evp_r, dec_ev_r,
                     SLOT_W'(dec_slot_r), dec_root_r, dec_hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy count disagrees with valid cells");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("occupancy exceeds table size");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CMP)
    else $error("accepted request did not enter compare cycle");
`endif

endmodule

@@ sv/lpcd_cell.sv @@
module lpcd_cell #(
  parameter int ENTRIES  = 64,
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 6,
  parameter int RANK_W   = 6,
  parameter int TAG_W    = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TAG_W-1:0]     key_i,
  input  lpcd_pkg::cell_cmd_t  cmd_i,
  input  logic [IDX_W-1:0]     cmd_slot_i,
  input  logic [RANK_W-1:0]    cmd_rank_i,
  input  logic [TAG_W-1:0]     cmd_tag_i,
  input  logic                 free_seen_i,
  output logic                 free_seen_o,
  output logic                 first_free_o,
  output logic                 match_o,
  output logic                 victim_o,
  output logic                 valid_o,
  output logic                 dirty_o,
  output logic [RANK_W-1:0]    rank_o,
  output logic [TAG_W-1:0]     tag_o
);
  import lpcd_pkg::*;

  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0]  MY_IDX    = IDX_W'(CELL_IDX);

  logic              valid_r, valid_nxt;
  logic              dirty_r, dirty_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic              sel;

  assign sel          = (cmd_slot_i == MY_IDX);
  assign match_o      = valid_r && (tag_r == key_i);
  assign victim_o     = valid_r && (rank_r == LAST_RANK);
  // lowest free slot: ripple through the row
  assign first_free_o = !valid_r && !free_seen_i;
  assign free_seen_o  = free_seen_i || !valid_r;
  assign valid_o      = valid_r;
  assign dirty_o      = dirty_r;
  assign rank_o       = rank_r;
  assign tag_o        = tag_r;

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    rank_nxt  = rank_r;
    tag_nxt   = tag_r;
    case (cmd_i.op)
      OP_TOUCH: begin
        if (sel) begin
          rank_nxt = '0;
          if (cmd_i.load) begin
            tag_nxt   = cmd_tag_i;
            valid_nxt = 1'b1;
            dirty_nxt = cmd_i.dirty;
          end else begin
            dirty_nxt = dirty_r | cmd_i.dirty;
          end
        end else if (valid_r && (cmd_i.age_all || rank_r < cmd_rank_i)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_DROP: begin
        if (sel) begin
          valid_nxt = 1'b0;
          dirty_nxt = 1'b0;
          rank_nxt  = '0;
        end else if (valid_r && rank_r > cmd_rank_i) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

@@ sv/lpcd_row.sv @@
module lpcd_row #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6,
  parameter int RANK_W  = 6,
  parameter int TAG_W   = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TAG_W-1:0]     key_i,
  input  lpcd_pkg::cell_cmd_t  cmd_i,
  input  logic [IDX_W-1:0]     cmd_slot_i,
  input  logic [RANK_W-1:0]    cmd_rank_i,
  input  logic [TAG_W-1:0]     cmd_tag_i,
  output logic                 hit_any_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [RANK_W-1:0]    hit_rank_o,
  output logic [IDX_W-1:0]     victim_idx_o,
  output logic [TAG_W-1:0]     victim_tag_o,
  output logic                 victim_dirty_o,
  output logic [IDX_W-1:0]     free_idx_o,
  output logic [ENTRIES-1:0]   valid_vec_o
);
  import lpcd_pkg::*;

  logic [ENTRIES:0]   free_chain;
  logic [ENTRIES-1:0] first_free;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] dirty;
  logic [RANK_W-1:0]  rank [ENTRIES];
  logic [TAG_W-1:0]   tag  [ENTRIES];

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lpcd_cell #(
      .ENTRIES  (ENTRIES),
      .CELL_IDX (g),
      .IDX_W    (IDX_W),
      .RANK_W   (RANK_W),
      .TAG_W    (TAG_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .key_i        (key_i),
      .cmd_i        (cmd_i),
      .cmd_slot_i   (cmd_slot_i),
      .cmd_rank_i   (cmd_rank_i),
      .cmd_tag_i    (cmd_tag_i),
      .free_seen_i  (free_chain[g]),
      .free_seen_o  (free_chain[g+1]),
      .first_free_o (first_free[g]),
      .match_o      (match[g]),
      .victim_o     (victim[g]),
      .valid_o      (valid_vec_o[g]),
      .dirty_o      (dirty[g]),
      .rank_o       (rank[g]),
      .tag_o        (tag[g])
    );
  end

  // at most one cell raises each flag, so plain OR gathers its fields
  always_comb begin
    hit_idx_o      = '0;
    hit_rank_o     = '0;
    victim_idx_o   = '0;
    victim_tag_o   = '0;
    victim_dirty_o = 1'b0;
    free_idx_o     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_idx_o      = hit_idx_o    | (match[i] ? IDX_W'(i) : '0);
      hit_rank_o     = hit_rank_o   | (match[i] ? rank[i] : '0);
      victim_idx_o   = victim_idx_o | (victim[i] ? IDX_W'(i) : '0);
      victim_tag_o   = victim_tag_o | (victim[i] ? tag[i] : '0);
      victim_dirty_o = victim_dirty_o | (victim[i] & dirty[i]);
      free_idx_o     = free_idx_o   | (first_free[i] ? IDX_W'(i) : '0);
    end
  end

  assign hit_any_o = |match;

endmodule

@@ tb/lpcd_checker.sv @@
// Watches both channels and the root register port, keeps a shadow copy of the
// LRU directory and compares every reply with the oldest predicted one.
module lpcd_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [lpcd_pkg::PAGE_W-1:0]     in_tdata,   // [47:0] page_offset
  input  logic [lpcd_pkg::MODE_W-1:0]     in_tuser,   // [1:0] mode
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] hit, [1] is_root, [7:2] slot, [8] evicted, [56:9] evicted_page,
  // [57] writeback, [58] not_present, [63:59] zero
  input  logic [lpcd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [lpcd_pkg::PAGE_W-1:0]     cfg_wr_data,
  output int                              fail_count,
  output int                              pending,
  output int                              n_requests,
  output int                              n_hits,
  output int                              n_evicts,
  output int                              n_writebacks,
  output int                              n_frees
);
  import lpcd_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;

  typedef struct packed {
    logic              hit;
    logic              is_root;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_page;
    logic              writeback;
    logic              not_present;
  } dir_reply_t;

  dir_reply_t        expected_replies[$];
  logic [PAGE_W-1:0] root_reg;
  logic [PAGE_W-1:0] tag_mem[ENTRIES];
  bit                line_valid[ENTRIES];
  bit                line_dirty[ENTRIES];
  int unsigned       lru_rank[ENTRIES];
  int unsigned       line_count;

  function automatic int find_line(input logic [PAGE_W-1:0] pg);
    int s;
    s = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (line_valid[i] && tag_mem[i] == pg) s = i;
    return s;
  endfunction

  // slot s becomes rank 0; valid entries newer than old_rank age by one
  function automatic void make_recent(input int s, input int unsigned old_rank);
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && i != s && lru_rank[i] < old_rank) lru_rank[i]++;
    lru_rank[s] = 0;
  endfunction

  function automatic dir_reply_t predict_reply(input logic [MODE_W-1:0] mode,
                                               input logic [PAGE_W-1:0] pg);
    dir_reply_t  r;
    int          s;
    int unsigned old_rank;
    r = '0;
    if (pg == root_reg) begin
      r.is_root = 1'b1;
      if (mode == MODE_FREE) r.not_present = 1'b1;
      else r.hit = 1'b1;
    end else if (mode == MODE_FREE) begin
      s = find_line(pg);
      if (s < 0) begin
        r.not_present = 1'b1;
      end else begin
        old_rank      = lru_rank[s];
        r.hit         = 1'b1;
        r.slot        = s[SLOT_W-1:0];
        line_valid[s] = 0;
        line_dirty[s] = 0;
        lru_rank[s]   = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (line_valid[i] && lru_rank[i] > old_rank) lru_rank[i]--;
        if (line_count > 0) line_count--;
      end
    end else begin
      s = find_line(pg);
      if (s >= 0) begin
        r.hit = 1'b1;
        make_recent(s, lru_rank[s]);
      end else begin
        s = 0;
        if (line_count >= ENTRIES) begin
          // table full: replace the least recent entry
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (line_valid[i] && lru_rank[i] == ENTRIES - 1) s = i;
          r.evicted      = 1'b1;
          r.evicted_page = tag_mem[s];
          r.writeback    = line_dirty[s];
          make_recent(s, ENTRIES);
        end else begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!line_valid[i]) s = i;
          line_count++;
          make_recent(s, ENTRIES);
        end
        tag_mem[s]    = pg;
        line_valid[s] = 1;
        line_dirty[s] = 0;
      end
      if (mode == MODE_WRITE) line_dirty[s] = 1;
      r.slot = s[SLOT_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [PAGE_W-1:0] want,
                             input logic [PAGE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: reply mismatch on %s: expected %h, got %h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    pending      = 0;
    n_requests   = 0;
    n_hits       = 0;
    n_evicts     = 0;
    n_writebacks = 0;
    n_frees      = 0;
  end

  always @(posedge clk) begin
    dir_reply_t want;
    dir_reply_t got;
    if (!rst_n) begin
      root_reg   = '0;
      line_count = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 0;
        line_dirty[i] = 0;
        lru_rank[i]   = 0;
      end
      expected_replies.delete();
    end else begin
      if (cfg_wr_en) root_reg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        want = predict_reply(in_tuser, in_tdata);
        expected_replies.insert(expected_replies.size(), want);
        n_requests++;
        if (want.hit && in_tuser != MODE_FREE) n_hits++;
        if (want.evicted) n_evicts++;
        if (want.writeback) n_writebacks++;
        if (in_tuser == MODE_FREE && want.hit) n_frees++;
      end
      if (out_tvalid && out_tready) begin
        got.hit          = out_tdata[0];
        got.is_root      = out_tdata[1];
        got.slot         = out_tdata[7:2];
        got.evicted      = out_tdata[8];
        got.evicted_page = out_tdata[56:9];
        got.writeback    = out_tdata[57];
        got.not_present  = out_tdata[58];
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply: expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("hit", want.hit, got.hit);
          check_field("is_root", want.is_root, got.is_root);
          check_field("slot", want.slot, got.slot);
          check_field("evicted", want.evicted, got.evicted);
          check_field("evicted_page", want.evicted_page, got.evicted_page);
          check_field("writeback", want.writeback, got.writeback);
          check_field("not_present", want.not_present, got.not_present);
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

@@ tb/tb_lru_page_cache_directory.sv @@
module tb_lru_page_cache_directory;
  import lpcd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused code, acts as a read
  localparam logic [PAGE_W-1:0] PAGE_ONES  = {PAGE_W{1'b1}};
  localparam int POOL_SIZE    = 96;   // larger than the table so evictions happen
  localparam int PHASE_ITEMS  = 280;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PAGE_W-1:0]     in_tdata;   // [47:0] page_offset
  logic [MODE_W-1:0]     in_tuser;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] hit, [1] is_root, [7:2] slot, [8] evicted, [56:9] evicted_page,
  // [57] writeback, [58] not_present, [63:59] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [PAGE_W-1:0]     cfg_wr_data;

  int fail_count, pending;
  int n_requests, n_hits, n_evicts, n_writebacks, n_frees;

  int                send_idle_pct;
  int                recv_idle_pct;
  int                phase_no;
  int                quiet_cycles;
  logic [PAGE_W-1:0] root_now;
  logic [PAGE_W-1:0] page_pool[POOL_SIZE];

  lru_page_cache_directory u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lpcd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .n_requests   (n_requests),
    .n_hits       (n_hits),
    .n_evicts     (n_evicts),
    .n_writebacks (n_writebacks),
    .n_frees      (n_frees)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random backpressure, plus one long hold-off in the last phase
  initial begin
    int  hold_left;
    bit  held;
    hold_left  = 0;
    held       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == 2 && !held) begin
        hold_left = HOLD_CYCLES;
        held      = 1;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or reply moved for %0d cycles", STALL_LIMIT);
        $display("tb_lru_page_cache_directory NOT OK");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = pg;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_root(input logic [PAGE_W-1:0] value);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    root_now    = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [PAGE_W-1:0] rand_page();
    return PAGE_W'({$urandom, $urandom});
  endfunction

  initial begin
    int                r;
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] pg;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = MODE_READ;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_no      = -1;
    quiet_cycles  = 0;
    root_now      = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: root at its reset value of zero
    send_req(MODE_READ, '0);
    send_req(MODE_WRITE, '0);
    send_req(MODE_FREE, '0);
    send_req(MODE_FREE, 48'h0000_0000_1000);  // free on an empty table
    send_req(MODE_READ, PAGE_ONES);
    send_req(MODE_WRITE, PAGE_ONES);
    send_req(MODE_SPARE, 48'h5555_5555_5555);
    send_req(MODE_WRITE, 48'hAAAA_AAAA_AAAA);
    send_req(MODE_READ, 48'h0000_0000_0001);
    send_req(MODE_FREE, 48'h5555_5555_5555);
    send_req(MODE_READ, 48'h0000_0000_0002);  // reuses the freed slot
    send_req(MODE_FREE, 48'h0000_0000_0003);
    // root moved onto a page that is still in the table
    write_root(PAGE_ONES);
    send_req(MODE_READ, PAGE_ONES);
    send_req(MODE_WRITE, PAGE_ONES);
    send_req(MODE_FREE, PAGE_ONES);
    send_req(MODE_READ, '0);
    send_req(MODE_WRITE, '0);
    send_req(MODE_FREE, '0);
    send_req(MODE_FREE, '0);
    send_req(MODE_SPARE, 48'hAAAA_AAAA_AAAA);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < POOL_SIZE; i++)
        page_pool[i] = (i % 4 == 0) ? PAGE_W'($urandom_range(0, 255)) << 12 : rand_page();
      case (p)
        0:       write_root(page_pool[$urandom_range(0, POOL_SIZE - 1)]);
        1:       write_root('0);
        default: write_root(48'h8000_0000_0001);
      endcase
      phase_no = p;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) mode = MODE_READ;
        else if (r < 75) mode = MODE_WRITE;
        else if (r < 80) mode = MODE_SPARE;
        else mode = MODE_FREE;
        r = $urandom_range(0, 99);
        if (r < 85) pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 92) pg = rand_page();
        else if (r < 96) pg = root_now;
        else pg = $urandom_range(0, 1) ? PAGE_ONES : '0;
        send_req(mode, pg);
      end
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("covered %0d requests: %0d access hits, %0d frees of cached pages,",
             n_requests, n_hits, n_frees);
    $display("%0d evictions of which %0d needed writeback", n_evicts, n_writebacks);
    if (fail_count == 0) begin
      $display("tb_lru_page_cache_directory OK");
    end else begin
      $display("tb_lru_page_cache_directory NOT OK");
    end
    $finish;
  end

endmodule
